FILE: sv/spfd_pkg.sv
// shared constants, register codes and control structs for the pulse frame decoder
// no dependencies; used by spfd_ctrl, spfd_dp and sbus_pulse_frame_decoder
package spfd_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int BITS_PER_BYTE = 12;
  localparam int CHANNEL_COUNT = 18;
  localparam int PULSE_BITS    = 16;

  localparam int WIDTH_W   = 16;
  localparam int VALUE_W   = 16;
  localparam int CHI_W     = 5;
  localparam int CH_BITS   = 11;

  localparam int PROP_CHANNELS = (CHANNEL_COUNT > 16) ? 16 : CHANNEL_COUNT;
  localparam int OUT_COUNT     = PROP_CHANNELS + ((CHANNEL_COUNT > 17) ? 2 : 0);
  localparam int PROP_W        = $clog2(PROP_CHANNELS);
  localparam int DATA_BYTES    = (PROP_CHANNELS * CH_BITS + 7) / 8;
  localparam int DATA_W        = DATA_BYTES * 8;
  localparam int FLAG_INDEX    = DATA_BYTES + 1;

  localparam int SLOT_W     = $clog2(FRAME_BYTES);
  localparam int POS_W      = $clog2(BITS_PER_BYTE);
  localparam int HIGH_LIMIT = BITS_PER_BYTE - 2;

  // (width + 1) / 10 as multiply by reciprocal, exact for operands up to 65536
  localparam int DIV10_RECIP = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int PROD_W      = 32;
  localparam int QW          = PROD_W - DIV10_SHIFT;

  localparam logic [7:0] HEADER_VALUE = 8'h0f;
  localparam logic [7:0] FLAG_BAD_MASK = 8'h0c;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGITAL_LOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGITAL_HIGH = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic rd;
    logic chk;
    logic emit_next;
  } spfd_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic byte_ok;
    logic last_byte;
    logic last_ch;
  } spfd_status_t;

endpackage

FILE: sv/spfd_ctrl.sv
// control state machine of the pulse frame decoder
// depends on spfd_pkg; drives the datapath spfd_dp through command and status structs
module spfd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  spfd_pkg::spfd_status_t status,
  output spfd_pkg::spfd_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = status.frame_end ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.chk = 1'b1;
        if (!status.byte_ok) begin
          state_next = S_IDLE;
        end else if (status.last_byte) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_READ;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          if (status.last_ch) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/spfd_dp.sv
// datapath of the pulse frame decoder: bit-time conversion, slot assembly,
// byte store, frame checks and channel extraction; depends on spfd_pkg
module spfd_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  spfd_pkg::spfd_cmd_t                    cmd,
  output spfd_pkg::spfd_status_t                 status,
  input  logic [spfd_pkg::WIDTH_W-1:0]           in_high,
  input  logic [spfd_pkg::WIDTH_W-1:0]           in_low,
  input  logic                                   cfg_we,
  input  logic [spfd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [spfd_pkg::VALUE_W-1:0]           cfg_wdata,
  output logic [spfd_pkg::CHI_W-1:0]             out_index,
  output logic [spfd_pkg::VALUE_W-1:0]           out_value,
  output logic                                   out_last
);

  localparam int BPB = spfd_pkg::BITS_PER_BYTE;
  localparam int QW  = spfd_pkg::QW;

  logic [spfd_pkg::VALUE_W-1:0] digital_low;
  logic [spfd_pkg::VALUE_W-1:0] digital_high;

  logic [QW-1:0]                  hi_bits;
  logic [QW-1:0]                  lo_bits;
  logic [spfd_pkg::PROD_W-1:0]    hi_prod;
  logic [spfd_pkg::PROD_W-1:0]    lo_prod;

  logic [spfd_pkg::SLOT_W-1:0]    slot;
  logic [spfd_pkg::POS_W-1:0]     pos;
  logic [BPB-1:0]                 cur;
  logic [BPB-1:0]                 mem [spfd_pkg::FRAME_BYTES];

  logic [spfd_pkg::SLOT_W-1:0]    idx;
  logic [BPB-1:0]                 rdata;
  logic [spfd_pkg::DATA_W-1:0]    data_bits;
  logic [1:0]                     flags;
  logic [spfd_pkg::CHI_W-1:0]     ch;

  // step logic
  logic [QW:0]                    hi_pos_sum;
  logic                           bad;
  logic [BPB-1:0]                 run;
  logic [BPB-1:0]                 cur_new;
  logic [spfd_pkg::POS_W-1:0]     pos_h;
  logic [spfd_pkg::POS_W-1:0]     room;
  logic                           wrap;
  logic [QW-1:0]                  lo_rem;
  logic                           last_slot;
  logic                           long_gap;
  logic                           resync;

  // check logic
  logic [BPB-1:0]                 v;
  logic [7:0]                     d;

  logic [spfd_pkg::CH_BITS-1:0]   chan [spfd_pkg::PROP_CHANNELS];

  assign hi_prod = spfd_pkg::PROD_W'((17'(in_high) + 17'd1) * 17'(spfd_pkg::DIV10_RECIP));
  assign lo_prod = spfd_pkg::PROD_W'((17'(in_low) + 17'd1) * 17'(spfd_pkg::DIV10_RECIP));

  always_comb begin
    hi_pos_sum = (QW+1)'(hi_bits) + (QW+1)'(pos);
    bad        = (hi_bits == '0) || (lo_bits == '0) ||
                 (hi_pos_sum > (QW+1)'(spfd_pkg::HIGH_LIMIT));
    run        = (BPB'(1) << hi_bits[spfd_pkg::POS_W-1:0]) - BPB'(1);
    cur_new    = cur | (run << pos);
    pos_h      = pos + hi_bits[spfd_pkg::POS_W-1:0];
    room       = spfd_pkg::POS_W'(BPB) - pos_h;
    wrap       = (lo_bits >= QW'(room));
    lo_rem     = wrap ? (lo_bits - QW'(room)) : '0;
    last_slot  = (slot == spfd_pkg::SLOT_W'(spfd_pkg::FRAME_BYTES - 1));
    long_gap   = (lo_rem > QW'(BPB));
    resync     = bad || long_gap || (wrap && last_slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digital_low  <= '0;
      digital_high <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        spfd_pkg::REG_DIGITAL_LOW:  digital_low  <= cfg_wdata;
        spfd_pkg::REG_DIGITAL_HIGH: digital_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_bits <= hi_prod[spfd_pkg::PROD_W-1:spfd_pkg::DIV10_SHIFT];
      lo_bits <= lo_prod[spfd_pkg::PROD_W-1:spfd_pkg::DIV10_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      pos  <= '0;
      cur  <= '0;
    end else if (cmd.step) begin
      if (resync) begin
        slot <= '0;
        pos  <= '0;
        cur  <= '0;
      end else if (wrap) begin
        slot <= slot + 1'b1;
        pos  <= '0;
        cur  <= '0;
      end else begin
        pos <= pos_h + lo_bits[spfd_pkg::POS_W-1:0];
        cur <= cur_new;
      end
    end
  end

  // completed slots are written in order, so every entry is fresh when checked
  always_ff @(posedge clk) begin
    if (cmd.step && !bad && wrap) begin
      mem[slot] <= cur_new;
    end
    if (cmd.rd) begin
      rdata <= mem[idx];
    end
  end

  assign v = ~rdata;
  assign d = v[8:1];

  always_comb begin
    status.frame_end = cmd.step && !bad && wrap && last_slot && long_gap;
    status.byte_ok   = !v[0] && (v[BPB-1:BPB-2] == 2'b11) && (v[9] == ^d) &&
                       ((idx != '0) || (d == spfd_pkg::HEADER_VALUE)) &&
                       ((idx != spfd_pkg::SLOT_W'(spfd_pkg::FLAG_INDEX)) ||
                        ((d & spfd_pkg::FLAG_BAD_MASK) == 8'h00));
    status.last_byte = (idx == spfd_pkg::SLOT_W'(spfd_pkg::FRAME_BYTES - 1));
    status.last_ch   = (ch == spfd_pkg::CHI_W'(spfd_pkg::OUT_COUNT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      ch  <= '0;
    end else begin
      if (cmd.step) begin
        idx <= '0;
      end else if (cmd.chk) begin
        idx <= idx + 1'b1;
        ch  <= '0;
      end else if (cmd.emit_next) begin
        ch <= ch + 1'b1;
      end
    end
  end

  // channel payload bytes shift in, first byte ends at the bottom
  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      if ((idx != '0) && (idx <= spfd_pkg::SLOT_W'(spfd_pkg::DATA_BYTES))) begin
        data_bits <= {d, data_bits[spfd_pkg::DATA_W-1:8]};
      end
      if (idx == spfd_pkg::SLOT_W'(spfd_pkg::FLAG_INDEX)) begin
        flags <= d[1:0];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < spfd_pkg::PROP_CHANNELS; c++) begin
      chan[c] = data_bits[c*spfd_pkg::CH_BITS +: spfd_pkg::CH_BITS];
    end
  end

  always_comb begin
    out_index = ch;
    out_last  = status.last_ch;
    if (ch < spfd_pkg::CHI_W'(spfd_pkg::PROP_CHANNELS)) begin
      out_value = spfd_pkg::VALUE_W'(chan[ch[spfd_pkg::PROP_W-1:0]])
                  << (spfd_pkg::PULSE_BITS - spfd_pkg::CH_BITS);
    end else if (ch == spfd_pkg::CHI_W'(spfd_pkg::PROP_CHANNELS)) begin
      out_value = flags[0] ? digital_high : digital_low;
    end else begin
      out_value = flags[1] ? digital_high : digital_low;
    end
  end

endmodule

FILE: sv/sbus_pulse_frame_decoder.sv
// top level of the pulse-width frame decoder: ports, controller and datapath
// depends on spfd_pkg, spfd_ctrl and spfd_dp
//
// channel  direction  content
// s_axis   in         tdata[15:0] high width us, tdata[31:16] low width us
// m_axis   out        tdata[4:0] channel index, tdata[20:5] channel value, tlast last channel
// cfg      in         cfg_index 0 digital low value, 1 digital high value
//
// an ordinary pulse pair converts its widths to bit times, then updates the slot
// a pair that closes a frame then reads and checks each of the 25 bytes (single read port)
// and then sends the 18 channels out, one channel per cycle while m_axis_tready is high
// one request is in flight at a time; s_axis_tready is low while it is worked on
// reset is synchronous and needs no clearing pass
module sbus_pulse_frame_decoder (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [31:0]                            s_axis_tdata,  // high_width_us, low_width_us
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [23:0]                            m_axis_tdata,  // channel_index, channel_value
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_we,
  input  logic [spfd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [spfd_pkg::VALUE_W-1:0]           cfg_wdata
);

  spfd_pkg::spfd_cmd_t    cmd;
  spfd_pkg::spfd_status_t status;

  logic [spfd_pkg::CHI_W-1:0]   channel_index;
  logic [spfd_pkg::VALUE_W-1:0] channel_value;

  spfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  spfd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_high   (s_axis_tdata[15:0]),
    .in_low    (s_axis_tdata[31:16]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_index (channel_index),
    .out_value (channel_value),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, channel_value, channel_index};

endmodule
